### src/five_point_stencil_smoother_assert.svh
// Assertion macros shared by the smoother modules
`ifndef FIVE_POINT_STENCIL_SMOOTHER_ASSERT_SVH
`define FIVE_POINT_STENCIL_SMOOTHER_ASSERT_SVH

// Property that must hold on every clock edge out of reset
`define FPSS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fpss: invariant violated");

// Same-cycle implication
`define FPSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpss: implication violated");

`endif

### src/fpss_pkg.sv
package fpss_pkg;

    localparam int PIXEL_BITS      = 16;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int WIDTH_RESET     = 1024;
    localparam int HEIGHT_RESET    = 1024;
    localparam int MIN_DIM         = 2;

    // 6c + n + 5 stays below 2^20
    localparam int SUM_BITS    = 20;
    // ceil(2^23 / 10); exact quotient for any sum below 2^22
    localparam int RECIP_SHIFT = 23;
    localparam logic [SUM_BITS-1:0] RECIP_TEN = 20'd838861;
    localparam logic [SUM_BITS-1:0] ROUND_BIAS = 20'd5;

    localparam int OUTQ_DEPTH = 4;

    // register indexes (paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    // one accepted request, as decoded against the frame position
    typedef struct packed {
        logic vld;
        logic flush;
        logic has_out;
        logic has_top;
        logic has_right;
        logic first_col;
        logic last;
        t_pix pix;
    } t_s0;

endpackage

### src/fpss_ram.sv
module fpss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### src/fpss_seq.sv
`include "five_point_stencil_smoother_assert.svh"

module fpss_seq #(
    parameter int MAX_WIDTH = fpss_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_restart,
    input  logic [fpss_pkg::WIDTH_REG_BITS-1:0]    i_frame_width,
    input  logic [fpss_pkg::HEIGHT_REG_BITS-1:0]   i_frame_height,
    input  logic                                   i_valid,
    input  logic                                   i_ready,
    input  logic                                   i_cmd,
    input  fpss_pkg::t_pix                         i_pix,
    output fpss_pkg::t_s0                          o_s0,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_col,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_col_next,
    output logic                                   o_credit_inc
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = (XW + 1 > fpss_pkg::WIDTH_REG_BITS) ? XW + 1 : fpss_pkg::WIDTH_REG_BITS;
    localparam int RW = fpss_pkg::HEIGHT_REG_BITS;

    logic [XW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] col_inc;
    logic          row_end;
    logic          flush_phase;
    logic          take;

    assign col_inc     = CW'(r_col) + CW'(1);
    assign row_end     = col_inc >= CW'(i_frame_width);
    assign flush_phase = r_row >= i_frame_height;
    // a request of the wrong kind for the current phase is dropped
    assign take        = i_valid && i_ready && (i_cmd == flush_phase);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (take) begin
            if (row_end) begin
                n_col = '0;
                n_row = i_cmd ? '0 : r_row + RW'(1);
            end else begin
                n_col = col_inc[XW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_s0.vld       = take;
        o_s0.flush     = i_cmd;
        o_s0.has_out   = i_cmd || (r_row != '0);
        o_s0.has_top   = i_cmd || (r_row > RW'(1));
        o_s0.has_right = !row_end;
        o_s0.first_col = (r_col == '0);
        o_s0.last      = i_cmd && row_end;
        o_s0.pix       = i_pix;
    end

    assign o_col        = r_col;
    assign o_col_next   = col_inc[XW-1:0];
    assign o_credit_inc = take && o_s0.has_out;

    `FPSS_ASSERT_ALWAYS(a_col_in_row, i_clk, i_rst_n, CW'(r_col) < CW'(i_frame_width))
    `FPSS_ASSERT_IMPLIES(a_row_bounded, i_clk, i_rst_n, 1'b1, r_row <= i_frame_height)

endmodule

### src/fpss_dp.sv
`include "five_point_stencil_smoother_assert.svh"

module fpss_dp #(
    parameter int MAX_WIDTH = fpss_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpss_pkg::t_s0                i_s0,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col_next,
    output logic                         o_push,
    output fpss_pkg::t_pix               o_pix,
    output logic                         o_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int PB = fpss_pkg::PIXEL_BITS;
    localparam int SB = fpss_pkg::SUM_BITS;
    localparam int RS = fpss_pkg::RECIP_SHIFT;

    // line store entry: upper row in the high half, centre row in the low half
    logic [2*PB-1:0] ram_a, ram_b, wr_data;

    fpss_pkg::t_s0   r_s1;
    logic [XW-1:0]   r_s1_x;
    logic            r_fwd_b;
    fpss_pkg::t_pix  r_fwd_data;
    fpss_pkg::t_pix  r_left;
    logic            r_s2_vld;
    logic [SB-1:0]   r_s2_sum;
    logic            r_s2_last;

    logic            s1_we;
    logic            n_fwd_b;
    fpss_pkg::t_pix  old_c, up, right;
    logic [SB-1:0]   c_ext, six_c, t_bot, t_left, t_right, t_top, sum;
    logic [2*SB-1:0] prod;

    fpss_ram #(
        .WIDTH (2*PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_waddr   (r_s1_x),
        .i_wdata   (wr_data),
        .i_raddr_a (i_col),
        .i_raddr_b (i_col_next),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    assign s1_we   = r_s1.vld && !r_s1.flush;
    // right-neighbor read can hit the entry written this cycle on narrow frames
    assign n_fwd_b = s1_we && (r_s1_x == i_col_next);

    assign old_c   = ram_a[PB-1:0];
    assign up      = ram_a[2*PB-1:PB];
    assign right   = r_fwd_b ? r_fwd_data : ram_b[PB-1:0];
    assign wr_data = {old_c, r_s1.pix};

    assign c_ext   = SB'(old_c);
    assign six_c   = (c_ext << 2) + (c_ext << 1);
    assign t_bot   = r_s1.flush     ? '0 : SB'(r_s1.pix);
    assign t_left  = r_s1.first_col ? '0 : SB'(r_left);
    assign t_right = r_s1.has_right ? SB'(right) : '0;
    assign t_top   = r_s1.has_top   ? SB'(up) : '0;
    assign sum     = six_c + t_bot + t_left + t_right + t_top + fpss_pkg::ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1     <= i_s0;
            r_s2_vld <= r_s1.vld && r_s1.has_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x     <= i_col;
        r_fwd_b    <= n_fwd_b;
        r_fwd_data <= r_s1.pix;
        if (r_s1.vld) begin
            r_left <= old_c;
        end
        r_s2_sum  <= sum;
        r_s2_last <= r_s1.last;
    end

    // divide by ten: reciprocal multiply, result registered in the output queue
    assign prod   = (2*SB)'(r_s2_sum) * (2*SB)'(fpss_pkg::RECIP_TEN);
    assign o_pix  = prod[RS+PB-1:RS];
    assign o_push = r_s2_vld;
    assign o_last = r_s2_last;

    `FPSS_ASSERT_IMPLIES(a_no_centre_hazard, i_clk, i_rst_n, s1_we, i_col != r_s1_x)
    `FPSS_ASSERT_IMPLIES(a_flush_no_write, i_clk, i_rst_n, r_s1.vld && r_s1.flush, !s1_we)

endmodule

### src/fpss_outq.sv
`include "five_point_stencil_smoother_assert.svh"

module fpss_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_credit_inc,
    input  logic           i_push,
    input  fpss_pkg::t_pix i_pix,
    input  logic           i_last,
    output logic           o_ready,
    output logic           o_tvalid,
    input  logic           i_tready,
    output fpss_pkg::t_pix o_tdata,
    output logic           o_tlast
);

    localparam int DEPTH = fpss_pkg::OUTQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    fpss_pkg::t_pix r_mem_pix  [DEPTH];
    logic           r_mem_last [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]  r_count, n_count;
    logic [NW-1:0]  r_credit, n_credit;
    logic           pop;

    assign pop      = o_tvalid && i_tready;
    assign o_tvalid = (r_count != '0);
    assign o_tdata  = r_mem_pix[r_rd_ptr];
    assign o_tlast  = r_mem_last[r_rd_ptr];
    // results owed to the output: accepted requests stop once the queue could overfill
    assign o_ready  = r_credit < NW'(DEPTH);

    always_comb begin
        n_count  = r_count + NW'(i_push) - NW'(pop);
        n_credit = r_credit + NW'(i_credit_inc) - NW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            r_count  <= n_count;
            r_credit <= n_credit;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem_pix[r_wr_ptr]  <= i_pix;
            r_mem_last[r_wr_ptr] <= i_last;
        end
    end

    `FPSS_ASSERT_ALWAYS(a_queue_within_credit, i_clk, i_rst_n, r_count <= r_credit)

endmodule

### src/five_point_stencil_smoother.sv
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata = pixel_in, tuser = cmd (1 = flush)
// m_axis    out  tvalid/tready        tdata = pixel_out, tlast = frame_last
// apb       cfg  psel/penable/pready  paddr 0 = frame_width, 4 = frame_height
//
// One request per cycle while the output is taken; the result of a request passes
// through line store read, weighted sum and divide by ten, in that order.
// The line store is one dual-read RAM holding upper and centre row per column.
// Synchronous reset clears counters, pipeline, output queue, resets frame size.
// Input stalls only when four results are owed to an output that is not taken.
module five_point_stencil_smoother #(
    parameter int MAX_WIDTH = fpss_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WB   = fpss_pkg::WIDTH_REG_BITS;
    localparam int HB   = fpss_pkg::HEIGHT_REG_BITS;
    localparam int WMAX = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int WRST = (fpss_pkg::WIDTH_RESET > WMAX) ? WMAX : fpss_pkg::WIDTH_RESET;

    logic [WB-1:0]  r_frame_width, n_frame_width;
    logic [HB-1:0]  r_frame_height, n_frame_height;
    logic           cfg_wr;
    logic [WB-1:0]  wr_w;
    logic [HB-1:0]  wr_h;

    fpss_pkg::t_s0  s0;
    logic [XW-1:0]  col, col_next;
    logic           credit_inc;
    logic           q_ready;
    logic           push, push_last;
    fpss_pkg::t_pix push_pix;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_w   = pwdata[WB-1:0];
    assign wr_h   = pwdata[HB-1:0];

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        if (cfg_wr) begin
            unique case (paddr[2])
                fpss_pkg::REG_FRAME_WIDTH: begin
                    priority if (wr_w < WB'(fpss_pkg::MIN_DIM)) begin
                        n_frame_width = WB'(fpss_pkg::MIN_DIM);
                    end else if (int'(wr_w) > WMAX) begin
                        n_frame_width = WB'(WMAX);
                    end else begin
                        n_frame_width = wr_w;
                    end
                end
                fpss_pkg::REG_FRAME_HEIGHT: begin
                    priority if (wr_h < HB'(fpss_pkg::MIN_DIM)) begin
                        n_frame_height = HB'(fpss_pkg::MIN_DIM);
                    end else if (wr_h > HB'(fpss_pkg::HEIGHT_LIMIT)) begin
                        n_frame_height = HB'(fpss_pkg::HEIGHT_LIMIT);
                    end else begin
                        n_frame_height = wr_h;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WB'(WRST);
            r_frame_height <= HB'(fpss_pkg::HEIGHT_RESET);
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
        end
    end

    always_comb begin
        unique case (paddr[2])
            fpss_pkg::REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            fpss_pkg::REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:                    prdata = '0;
        endcase
    end

    fpss_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_wr),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (s_axis_tvalid),
        .i_ready        (q_ready),
        .i_cmd          (s_axis_tuser),
        .i_pix          (s_axis_tdata),
        .o_s0           (s0),
        .o_col          (col),
        .o_col_next     (col_next),
        .o_credit_inc   (credit_inc)
    );

    fpss_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s0       (s0),
        .i_col      (col),
        .i_col_next (col_next),
        .o_push     (push),
        .o_pix      (push_pix),
        .o_last     (push_last)
    );

    fpss_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_credit_inc (credit_inc),
        .i_push       (push),
        .i_pix        (push_pix),
        .i_last       (push_last),
        .o_ready      (q_ready),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

    assign s_axis_tready = q_ready;

endmodule
